[src/dqpt_pkg.sv]
package dqpt_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OPND_W   = WORD_W + 1;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned IDX_W    = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROT_W   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT_X   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT_Y   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROT_Z   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRANS_W = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANS_X = 3'd5;
  localparam logic [IDX_W-1:0] REG_TRANS_Y = 3'd6;
  localparam logic [IDX_W-1:0] REG_TRANS_Z = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] w;
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } quat_t;

  // One extra bit so that negating the most negative value does not wrap
  typedef struct packed {
    logic signed [OPND_W-1:0] w;
    logic signed [OPND_W-1:0] x;
    logic signed [OPND_W-1:0] y;
    logic signed [OPND_W-1:0] z;
  } quat_ext_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [WORD_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
    logic                     ovf;
  } result_t;

  // Clamp a 33-bit sum to the 32-bit signed range
  function automatic sat_t sat33(input logic signed [OPND_W-1:0] v);
    sat_t s;
    s.ovf = v[OPND_W-1] ^ v[WORD_W-1];
    if (!s.ovf) begin
      s.val = v[WORD_W-1:0];
    end else if (v[OPND_W-1]) begin
      s.val = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      s.val = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return s;
  endfunction

  function automatic quat_ext_t qext(input quat_t q);
    quat_ext_t r;
    r.w = {q.w[WORD_W-1], q.w};
    r.x = {q.x[WORD_W-1], q.x};
    r.y = {q.y[WORD_W-1], q.y};
    r.z = {q.z[WORD_W-1], q.z};
    return r;
  endfunction

  // Conjugate at full width
  function automatic quat_ext_t qconj(input quat_t q);
    quat_ext_t r;
    r   = qext(q);
    r.x = -r.x;
    r.y = -r.y;
    r.z = -r.z;
    return r;
  endfunction

endpackage

[src/dqpt_qprod.sv]
module dqpt_qprod import dqpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  quat_ext_t                                   a,
  input  quat_ext_t                                   b,
  output logic signed [2*OPND_W-FRAC_BITS-1:0]        prod_r [16]
);

  localparam int PROD_W = 2 * OPND_W;
  localparam logic signed [PROD_W-1:0] HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic signed [OPND_W-1:0] av [4];
  logic signed [OPND_W-1:0] bv [4];
  logic signed [PROD_W-1:0] full [16];

  assign av[0] = a.w;
  assign av[1] = a.x;
  assign av[2] = a.y;
  assign av[3] = a.z;
  assign bv[0] = b.w;
  assign bv[1] = b.x;
  assign bv[2] = b.y;
  assign bv[3] = b.z;

  // Form all sixteen cross products, add one half for rounding
  for (genvar i = 0; i < 4; i++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      assign full[4*i+j] = av[i] * bv[j] + HALF;

      // Drop the fraction bits (floor) and register
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[4*i+j] <= full[4*i+j][PROD_W-1:FRAC_BITS];
        end
      end
    end
  end

endmodule

[src/dqpt_qsum.sv]
module dqpt_qsum import dqpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic signed [2*OPND_W-FRAC_BITS-1:0] prod [16],
  output quat_t                                sum_r,
  output logic                                 ovf_r
);

  localparam int RND_W = 2 * OPND_W - FRAC_BITS;
  localparam int SUM_W = RND_W + 2;
  localparam logic signed [SUM_W-1:0] MAXV = (SUM_W'(1) << (WORD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] MINV = -(SUM_W'(1) << (WORD_W - 1));

  logic signed [SUM_W-1:0] pe [16];
  logic signed [SUM_W-1:0] s  [4];
  logic signed [WORD_W-1:0] v [4];
  logic [3:0]               hit;

  for (genvar k = 0; k < 16; k++) begin : g_ext
    assign pe[k] = SUM_W'(prod[k]);
  end

  // Hamilton product: product k is a component (k/4) times b component (k%4)
  assign s[0] = pe[0]  - pe[5]  - pe[10] - pe[15];
  assign s[1] = pe[1]  + pe[4]  + pe[11] - pe[14];
  assign s[2] = pe[2]  - pe[7]  + pe[8]  + pe[13];
  assign s[3] = pe[3]  + pe[6]  - pe[9]  + pe[12];

  // Saturate each component to 32 bits
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit[k] = 1'b0;
      v[k]   = s[k][WORD_W-1:0];
      if (s[k] > MAXV) begin
        hit[k] = 1'b1;
        v[k]   = MAXV[WORD_W-1:0];
      end else if (s[k] < MINV) begin
        hit[k] = 1'b1;
        v[k]   = MINV[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r.w <= v[0];
      sum_r.x <= v[1];
      sum_r.y <= v[2];
      sum_r.z <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (en) begin
      ovf_r <= |hit;
    end
  end

endmodule

[src/dqpt_skid.sv]
module dqpt_skid import dqpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pipe_valid,
  input  result_t pipe_data,
  input  logic    out_stall,
  output logic    hold,
  output logic    out_valid,
  output result_t out_data
);

  logic    skid_valid_r;
  result_t skid_data_r;

  // Catch the last stage's word when the sink stalls, release when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (pipe_valid && out_stall) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_data_r <= pipe_data;
    end
  end

  assign hold      = skid_valid_r;
  assign out_valid = skid_valid_r | pipe_valid;
  assign out_data  = skid_valid_r ? skid_data_r : pipe_data;

endmodule

[src/dual_quaternion_point_transform.sv]
// Throughput: one point per cycle while the skid register is empty. Six register stages
// run under one enable (stage 1 forms 32 parallel 33x33 products, stage 4 another 16,
// the rest add and saturate). A stalled output word is caught in a skid register,
// which stalls the input.
// Reset (rst_n low, synchronous) clears all valid bits and loads the identity
// transform: rot_w = 1.0, all other components 0.
module dual_quaternion_point_transform import dqpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] in_point_x,
  input  logic signed [WORD_W-1:0] in_point_y,
  input  logic signed [WORD_W-1:0] in_point_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_x,
  output logic signed [WORD_W-1:0] out_y,
  output logic signed [WORD_W-1:0] out_z,
  output logic                     out_overflow,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [WORD_W-1:0]        cfg_wdata
);

  localparam int RND_W = 2 * OPND_W - FRAC_BITS;
  localparam logic [WORD_W-1:0] ONE_FX = WORD_W'(64'd1 << FRAC_BITS);

  logic [WORD_W-1:0] cfg_r [NUM_REGS];
  quat_t             rot_q, trans_q;
  quat_ext_t         p_ext, rc_ext;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [RND_W-1:0] a_prod [16];
  logic signed [RND_W-1:0] e_prod [16];
  logic signed [RND_W-1:0] c_prod [16];

  quat_t a_q, e_q, c_q;
  logic  a_ovf, e_ovf, c_ovf;

  quat_t   b_r, e3_r, e4_r, e5_r;
  logic    f3_r, f4_r, f5_r;
  sat_t    bs_w, bs_x, bs_y, bs_z;
  sat_t    os_x, os_y, os_z;
  result_t res_r, out_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
      cfg_r[REG_ROT_W] <= ONE_FX;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign rot_q.w   = cfg_r[REG_ROT_W];
  assign rot_q.x   = cfg_r[REG_ROT_X];
  assign rot_q.y   = cfg_r[REG_ROT_Y];
  assign rot_q.z   = cfg_r[REG_ROT_Z];
  assign trans_q.w = cfg_r[REG_TRANS_W];
  assign trans_q.x = cfg_r[REG_TRANS_X];
  assign trans_q.y = cfg_r[REG_TRANS_Y];
  assign trans_q.z = cfg_r[REG_TRANS_Z];

  assign rc_ext  = qconj(rot_q);
  assign p_ext.w = '0;
  assign p_ext.x = {in_point_x[WORD_W-1], in_point_x};
  assign p_ext.y = {in_point_y[WORD_W-1], in_point_y};
  assign p_ext.z = {in_point_z[WORD_W-1], in_point_z};

  // Whole pipeline advances unless the skid register holds a word
  assign adv      = !in_stall;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 1: products of p * r* and d * r*
  dqpt_qprod #(.FRAC_BITS(FRAC_BITS)) u_prod_a (
    .clk    (clk),
    .en     (adv),
    .a      (p_ext),
    .b      (rc_ext),
    .prod_r (a_prod)
  );

  dqpt_qprod #(.FRAC_BITS(FRAC_BITS)) u_prod_e (
    .clk    (clk),
    .en     (adv),
    .a      (qext(trans_q)),
    .b      (rc_ext),
    .prod_r (e_prod)
  );

  // Stage 2: sum and saturate to a and e
  dqpt_qsum #(.FRAC_BITS(FRAC_BITS)) u_sum_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .prod  (a_prod),
    .sum_r (a_q),
    .ovf_r (a_ovf)
  );

  dqpt_qsum #(.FRAC_BITS(FRAC_BITS)) u_sum_e (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .prod  (e_prod),
    .sum_r (e_q),
    .ovf_r (e_ovf)
  );

  // Stage 3: b = a - d*
  assign bs_w = sat33({a_q.w[WORD_W-1], a_q.w} - {trans_q.w[WORD_W-1], trans_q.w});
  assign bs_x = sat33({a_q.x[WORD_W-1], a_q.x} + {trans_q.x[WORD_W-1], trans_q.x});
  assign bs_y = sat33({a_q.y[WORD_W-1], a_q.y} + {trans_q.y[WORD_W-1], trans_q.y});
  assign bs_z = sat33({a_q.z[WORD_W-1], a_q.z} + {trans_q.z[WORD_W-1], trans_q.z});

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r.w <= bs_w.val;
      b_r.x <= bs_x.val;
      b_r.y <= bs_y.val;
      b_r.z <= bs_z.val;
      e3_r  <= e_q;
      f3_r  <= a_ovf | e_ovf | bs_w.ovf | bs_x.ovf | bs_y.ovf | bs_z.ovf;
      e4_r  <= e3_r;
      f4_r  <= f3_r;
      e5_r  <= e4_r;
      f5_r  <= f4_r;
    end
  end

  // Stage 4: products of r * b
  dqpt_qprod #(.FRAC_BITS(FRAC_BITS)) u_prod_c (
    .clk    (clk),
    .en     (adv),
    .a      (qext(rot_q)),
    .b      (qext(b_r)),
    .prod_r (c_prod)
  );

  // Stage 5: sum and saturate to c
  dqpt_qsum #(.FRAC_BITS(FRAC_BITS)) u_sum_c (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .prod  (c_prod),
    .sum_r (c_q),
    .ovf_r (c_ovf)
  );

  // Stage 6: vector part of c + e
  assign os_x = sat33({c_q.x[WORD_W-1], c_q.x} + {e5_r.x[WORD_W-1], e5_r.x});
  assign os_y = sat33({c_q.y[WORD_W-1], c_q.y} + {e5_r.y[WORD_W-1], e5_r.y});
  assign os_z = sat33({c_q.z[WORD_W-1], c_q.z} + {e5_r.z[WORD_W-1], e5_r.z});

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.x   <= os_x.val;
      res_r.y   <= os_y.val;
      res_r.z   <= os_z.val;
      res_r.ovf <= f5_r | c_ovf | os_x.ovf | os_y.ovf | os_z.ovf;
    end
  end

  // Output skid
  dqpt_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (v6_r),
    .pipe_data  (res_r),
    .out_stall  (out_stall),
    .hold       (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_word)
  );

  assign out_x        = out_word.x;
  assign out_y        = out_word.y;
  assign out_z        = out_word.z;
  assign out_overflow = out_word.ovf;

  // A held skid word freezes the valid bits of every stage
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r}))
    else $error("pipeline moved while skid held a word");

  // The skid fills only from a stalled output word
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  // A taken skid word clears the skid register, which releases the input
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("skid did not release after its word was taken");

  // An accepted word enters stage one
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted word lost at stage one");

endmodule
